### hw/rtl/greedy_list_scheduler_macros.svh
// assertion helpers for the greedy list scheduler
`ifndef GREEDY_LIST_SCHEDULER_MACROS_SVH
`define GREEDY_LIST_SCHEDULER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define GLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define GLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gls_pkg.sv
`default_nettype none

package gls_pkg;

  localparam logic [31:0] LoadMax  = 32'hFFFF_FFFF;
  localparam logic [15:0] CountMax = 16'hFFFF;

  // one input transfer
  typedef struct packed {
    logic [15:0] task_length;
    logic        batch_start;
  } in_t;

  // one result transfer
  typedef struct packed {
    logic [3:0]  cpu_index;
    logic [15:0] slot_index;
    logic [31:0] new_load;
    logic [31:0] makespan;
  } out_t;

  // search wave passed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [31:0] min_load;
    logic [15:0] min_cnt;
    logic [31:0] max_load;
  } wave_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic        clr;
    logic        en;
    logic [31:0] new_load;
    logic [15:0] new_cnt;
  } upd_t;

endpackage

`default_nettype wire

### hw/rtl/greedy_list_scheduler.sv
// greedy list scheduler
// input channel: in_valid_i / in_ready_o carry a task length and a batch-start
// flag; each task goes to the least-loaded active processor, lowest index on ties.
// output channel: out_valid_o / out_ready_i carry processor index, slot, new
// load and makespan, exactly one result per task, in order.
// cfg_we_i / cfg_wdata_i write the active processor count (0 acts as 1, values
// above MAX_CPUS act as MAX_CPUS); write only while idle.
// a search wave runs through a row of MAX_CPUS cells, one cell per cycle; the
// next task is taken only after the previous task's result has been written
// to the output register.
// the result sits in an output register; a new task is taken while it waits.
// if the receiver stalls when the next result is ready, the processor update
// and the result are held until the output register is free.
// reset clears all loads and counts at once and sets the active count to 16.
`default_nettype none

module greedy_list_scheduler #(
  parameter int unsigned MAX_CPUS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gls_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gls_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [4:0]    cfg_wdata_i
);
  import gls_pkg::*;

  `include "greedy_list_scheduler_macros.svh"

  localparam int unsigned IDX_W = $clog2(MAX_CPUS);
  localparam int unsigned CNT_W = $clog2(MAX_CPUS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_PEND = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [4:0]       cfg_q;
  logic [CNT_W-1:0] eff_n;
  logic [15:0]      len_q;
  logic             start_q;
  logic             out_valid_q;
  out_t             out_q;
  logic             in_xfer, out_free, fire;
  logic [32:0]      sum;
  logic [31:0]      new_load;
  logic [31:0]      span;
  upd_t             upd;
  logic [MAX_CPUS-1:0] act;

  wave_t            wave [MAX_CPUS+1];
  logic [IDX_W-1:0] widx [MAX_CPUS+1];
  wave_t            last;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 5'd16;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // effective processor count
  always_comb begin
    if (cfg_q == 5'd0) begin
      eff_n = CNT_W'(1);
    end else if (32'(cfg_q) > MAX_CPUS) begin
      eff_n = CNT_W'(MAX_CPUS);
    end else begin
      eff_n = CNT_W'(cfg_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last       = wave[MAX_CPUS];
  assign fire       = (((state_q == S_RUN) && last.vld) || (state_q == S_PEND)) && out_free;

  // control sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_RUN;
      end
      S_RUN: begin
        if (last.vld) state_d = out_free ? S_IDLE : S_PEND;
      end
      S_PEND: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) len_q <= in_data_i.task_length;
  end

  // seed of the search wave
  always_comb begin
    wave[0].vld      = start_q;
    wave[0].min_load = LoadMax;
    wave[0].min_cnt  = '0;
    wave[0].max_load = '0;
    widx[0]          = '0;
  end

  // row of processor cells
  for (genvar k = 0; k < MAX_CPUS; k++) begin : g_cell
    assign act[k] = (32'(k) < 32'(eff_n));
    gls_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .act_i  (act[k]),
      .wave_i (wave[k]),
      .idx_i  (widx[k]),
      .wave_o (wave[k+1]),
      .idx_o  (widx[k+1]),
      .upd_i  (upd),
      .sel_i  (widx[MAX_CPUS])
    );
  end

  // saturating load update and makespan
  assign sum      = {1'b0, last.min_load} + {17'b0, len_q};
  assign new_load = sum[32] ? LoadMax : sum[31:0];
  assign span     = (new_load > last.max_load) ? new_load : last.max_load;

  always_comb begin
    upd.clr      = in_xfer && in_data_i.batch_start;
    upd.en       = fire;
    upd.new_load = new_load;
    upd.new_cnt  = (last.min_cnt == CountMax) ? CountMax : (last.min_cnt + 16'd1);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.cpu_index  <= 4'(widx[MAX_CPUS]);
      out_q.slot_index <= last.min_cnt;
      out_q.new_load   <= new_load;
      out_q.makespan   <= span;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `GLS_ASSERT_NXT(a_xfer_starts, in_xfer, state_q == S_RUN, "transfer did not start search")
  `GLS_ASSERT_IMP(a_wave_in_run, last.vld, state_q == S_RUN, "search wave ended outside run")
  `GLS_ASSERT_NXT(a_fire_out, fire, out_valid_o, "update without result")
  `GLS_ASSERT_NXT(a_pend_hold, (state_q == S_PEND) && out_valid_o && !out_ready_i,
                  state_q == S_PEND, "pending result left while output stalled")

endmodule

`default_nettype wire

### hw/rtl/gls_cell.sv
`default_nettype none

module gls_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             act_i,
  input  wire gls_pkg::wave_t   wave_i,
  input  wire logic [IDX_W-1:0] idx_i,
  output gls_pkg::wave_t        wave_o,
  output logic [IDX_W-1:0]      idx_o,
  input  wire gls_pkg::upd_t    upd_i,
  input  wire logic [IDX_W-1:0] sel_i
);
  import gls_pkg::*;

  logic [31:0]      load_q;
  logic [15:0]      cnt_q;
  logic             vld_q;
  wave_t            wave_d, wave_q;
  logic [IDX_W-1:0] idx_d, idx_q;
  logic             take;

  // processor state: cleared on batch start, written when chosen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      cnt_q  <= '0;
    end else if (upd_i.clr) begin
      load_q <= '0;
      cnt_q  <= '0;
    end else if (upd_i.en && (sel_i == IDX_W'(IDX))) begin
      load_q <= upd_i.new_load;
      cnt_q  <= upd_i.new_cnt;
    end
  end

  // fold this cell into the running min and max
  // cell zero always opens the minimum, so a fully saturated row still picks it
  assign take = act_i && ((IDX == 0) || (load_q < wave_i.min_load));

  always_comb begin
    wave_d = wave_i;
    idx_d  = idx_i;
    if (take) begin
      wave_d.min_load = load_q;
      wave_d.min_cnt  = cnt_q;
      idx_d           = IDX_W'(IDX);
    end
    if (act_i && (load_q > wave_i.max_load)) begin
      wave_d.max_load = load_q;
    end
  end

  // wave valid pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= wave_i.vld;
    end
  end

  // wave payload holds until the next wave passes
  always_ff @(posedge clk_i) begin
    if (wave_i.vld) begin
      wave_q <= wave_d;
      idx_q  <= idx_d;
    end
  end

  always_comb begin
    wave_o     = wave_q;
    wave_o.vld = vld_q;
  end
  assign idx_o = idx_q;

endmodule

`default_nettype wire

### verif/gls_checker.sv
module gls_checker
  import gls_pkg::*;
#(
  parameter int unsigned MAX_CPUS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_t       out_data_i,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the scheduler state
  logic [31:0] shadow_load [MAX_CPUS];
  logic [15:0] shadow_count [MAX_CPUS];
  logic [4:0]  shadow_active;

  // placements predicted but not yet seen on the output
  out_t placement_q [$];

  task automatic clear_shadow();
    for (int i = 0; i < MAX_CPUS; i++) begin
      shadow_load[i]  = '0;
      shadow_count[i] = '0;
    end
  endtask

  // place one task on the least-loaded active processor
  task automatic place_task(input in_t item, output out_t res);
    int unsigned n;
    int unsigned best;
    logic [32:0] sum;
    logic [31:0] span;
    n = 32'(shadow_active);
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_CPUS) begin
      n = MAX_CPUS;
    end
    if (item.batch_start) begin
      clear_shadow();
    end
    // strict compare keeps the lowest index on ties
    best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (shadow_load[i] < shadow_load[best]) begin
        best = i;
      end
    end
    res.cpu_index  = best[3:0];
    res.slot_index = shadow_count[best];
    if (shadow_count[best] != CountMax) begin
      shadow_count[best] = shadow_count[best] + 16'd1;
    end
    // saturating load update
    sum = {1'b0, shadow_load[best]} + {17'd0, item.task_length};
    shadow_load[best] = sum[32] ? LoadMax : sum[31:0];
    res.new_load = shadow_load[best];
    span = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (shadow_load[i] > span) begin
        span = shadow_load[i];
      end
    end
    res.makespan = span;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  // watch transfers on all channels
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      clear_shadow();
      shadow_active = 5'd16;
      placement_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // result transfer against the oldest placement
      if (out_valid_i && out_ready_i) begin
        if (placement_q.size() == 0) begin
          $error("result transfer with no task waiting: cpu_index %0d new_load %0d",
                 out_data_i.cpu_index, out_data_i.new_load);
          errors_o++;
        end else begin
          want = placement_q.pop_front();
          check_field("cpu_index", 32'(want.cpu_index), 32'(out_data_i.cpu_index));
          check_field("slot_index", 32'(want.slot_index), 32'(out_data_i.slot_index));
          check_field("new_load", want.new_load, out_data_i.new_load);
          check_field("makespan", want.makespan, out_data_i.makespan);
        end
      end
      if (cfg_we_i) begin
        shadow_active = cfg_wdata_i;
      end
      // task transfer
      if (in_valid_i && in_ready_i) begin
        place_task(in_data_i, want);
        placement_q.push_back(want);
      end
      pending_o = placement_q.size();
    end
  end

endmodule

### verif/tb_top.sv
module tb_top;
  import gls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCpus  = 16;
  localparam int          GapMax   = 10;
  localparam int          HoldAt   = 300;
  localparam int          HoldLen  = 400;
  localparam int          RandTasks = 1150;
  localparam int          SoloTasks = 60;
  localparam int          DrainCycles = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int errors;
  int pending;
  int tasks_sent = 0;
  int cfg_writes = 0;
  int results_taken = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  greedy_list_scheduler #(
    .MAX_CPUS(NumCpus)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  gls_checker #(
    .MAX_CPUS(NumCpus)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // offer one task and wait for its transfer
  task automatic send_task(input logic [15:0] len, input logic start);
    int gap;
    gap = tx_idle ? $urandom_range(0, GapMax) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data  <= '{task_length: len, batch_start: start};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    @(negedge clk_i);
    tasks_sent++;
  endtask

  // drain the block, then write the active processor count
  task automatic write_active(input logic [4:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (results_taken == HoldAt) begin
        gap = HoldLen;
      end else begin
        gap = rx_idle ? $urandom_range(0, GapMax) : 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      results_taken++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int rand_end;
    int since_cfg;
    int batch_len;
    logic [15:0] len;
    logic start;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, ties, inactive processors, out-of-range counts
    send_task(16'd0, 1'b1);
    send_task(16'hFFFF, 1'b0);
    send_task(16'hFFFF, 1'b0);
    send_task(16'd1, 1'b0);
    send_task(16'd0, 1'b0);
    send_task(16'd40000, 1'b0);
    write_active(5'd1);
    send_task(16'd5, 1'b0);
    send_task(16'hFFFF, 1'b1);
    send_task(16'd7, 1'b0);
    write_active(5'd0);
    send_task(16'd3, 1'b0);
    send_task(16'd0, 1'b0);
    write_active(5'd31);
    send_task(16'd2, 1'b0);
    send_task(16'hFFFF, 1'b0);
    send_task(16'd100, 1'b0);
    write_active(5'd17);
    send_task(16'd9, 1'b0);
    send_task(16'd9, 1'b1);
    write_active(5'd3);
    send_task(16'd1, 1'b1);
    send_task(16'd1, 1'b0);
    send_task(16'd1, 1'b0);
    send_task(16'd1, 1'b0);
    // processors above three rejoin with their kept loads
    write_active(5'd16);
    send_task(16'd12345, 1'b0);
    send_task(16'd0, 1'b0);

    // random batches, each opened by a batch start
    rand_end  = tasks_sent + RandTasks;
    since_cfg = 0;
    while (tasks_sent < rand_end) begin
      if (since_cfg >= 150) begin
        case ($urandom_range(0, 5))
          0:       write_active(5'd1);
          1:       write_active(5'd16);
          2:       write_active(5'd31);
          3:       write_active(5'd0);
          default: write_active(5'($urandom_range(0, 31)));
        endcase
        since_cfg = 0;
      end
      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      batch_len = $urandom_range(1, 40);
      for (int k = 0; k < batch_len; k++) begin
        case ($urandom_range(0, 7))
          0:       len = 16'd0;
          1:       len = 16'hFFFF;
          2:       len = 16'($urandom_range(0, 15));
          default: len = 16'($urandom);
        endcase
        // stray batch starts in the middle of a batch
        start = (k == 0) || ($urandom_range(0, 19) == 0);
        send_task(len, start);
        since_cfg++;
      end
    end

    // one processor loaded back to back with long tasks, no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_active(5'd1);
    send_task(16'hFFFF, 1'b1);
    for (int k = 1; k < SoloTasks; k++) begin
      send_task(16'hFFFF, 1'b0);
    end
    write_active(5'd2);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (3) send_task(16'($urandom), 1'b0);

    // drain
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("covered %0d tasks and %0d writes of the active processor count,",
             tasks_sent, cfg_writes);
    $display("with random batches, a long output stall and a back-to-back run on one processor");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### greedy_list_scheduler.f
+incdir+hw/rtl
hw/rtl/gls_pkg.sv
hw/rtl/gls_cell.sv
hw/rtl/greedy_list_scheduler.sv
verif/gls_checker.sv
verif/tb_top.sv
